### hdl/tgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_pkg
// shared constants for the triangle gradient coefficient pipeline
// ----------------------------------------------------------------------------
package tgc_pkg;

  // default field widths
  localparam int COORD_BITS_DEF = 32;
  localparam int INDEX_BITS_DEF = 24;

  // quotients are scaled by two to this power before division
  localparam int FRAC_SHIFT = 32;

  // number of coefficient lanes: three for perp13, three for perp21
  localparam int LANES = 6;

endpackage
`default_nettype wire

### hdl/tgc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_div
// pipelined restoring divider, one quotient bit per stage, shared divisor,
// rounding to nearest (ties away from zero) and signed saturation
// ----------------------------------------------------------------------------
module tgc_div import tgc_pkg::*; #(
  parameter int CW = COORD_BITS_DEF,
  parameter int DW = 136,
  parameter int XW = 101
) (
  input  logic                         clk,
  input  logic [DW-1:0]                d,
  input  logic [LANES-1:0][XW-1:0]     mag,
  input  logic [LANES-1:0]             neg,
  output logic [LANES-1:0][CW-1:0]     q
);

  localparam int NUMW = XW + FRAC_SHIFT;
  localparam int DENW = DW + CW;
  localparam int TW   = ((NUMW > DENW) ? NUMW : DENW) + 1;

  logic [DW-1:0]                 d_s   [0:CW];
  logic [LANES-1:0][DW-1:0]      rem_s [0:CW];
  logic [LANES-1:0][CW-1:0]      q_s   [0:CW];
  logic [LANES-1:0][CW-1:0]      nb_s  [0:CW-1];
  logic [LANES-1:0]              neg_s [0:CW];
  logic [LANES-1:0]              sat_s [0:CW];

  // stage 0: early overflow check and initial partial remainder
  always_ff @(posedge clk) begin
    d_s[0] <= d;
  end

  for (genvar l = 0; l < LANES; l++) begin : g_pre
    logic [TW-1:0] num_w;
    logic [TW-1:0] den_w;
    always_comb begin
      num_w = TW'({mag[l], {FRAC_SHIFT{1'b0}}});
      den_w = TW'({d, {CW{1'b0}}});
    end
    always_ff @(posedge clk) begin
      sat_s[0][l] <= (num_w >= den_w);
      rem_s[0][l] <= DW'(num_w >> CW);
      nb_s[0][l]  <= num_w[CW-1:0];
      q_s[0][l]   <= '0;
      neg_s[0][l] <= neg[l];
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar s = 1; s <= CW; s++) begin : g_step
    always_ff @(posedge clk) begin
      d_s[s]   <= d_s[s-1];
      neg_s[s] <= neg_s[s-1];
      sat_s[s] <= sat_s[s-1];
    end
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DW:0] rsh;
      logic        ge;
      always_comb begin
        rsh = {rem_s[s-1][l], nb_s[s-1][l][CW-1]};
        ge  = (rsh >= {1'b0, d_s[s-1]});
      end
      always_ff @(posedge clk) begin
        rem_s[s][l] <= ge ? DW'(rsh - {1'b0, d_s[s-1]}) : DW'(rsh);
        q_s[s][l]   <= {q_s[s-1][l][CW-2:0], ge};
      end
      if (s < CW) begin : g_nb
        always_ff @(posedge clk) begin
          nb_s[s][l] <= {nb_s[s-1][l][CW-2:0], 1'b0};
        end
      end
    end
  end

  // rounding and saturation
  for (genvar l = 0; l < LANES; l++) begin : g_fin
    logic          up;
    logic [CW:0]   qr;
    logic          ovf;
    always_comb begin
      up  = ({rem_s[CW][l], 1'b0} >= {1'b0, d_s[CW]});
      qr  = {1'b0, q_s[CW][l]} + (CW+1)'(up);
      ovf = sat_s[CW][l] ||
            (neg_s[CW][l] ? (qr > (CW+1)'({1'b1, {(CW-1){1'b0}}}))
                          : (qr > (CW+1)'({1'b0, {(CW-1){1'b1}}})));
    end
    always_ff @(posedge clk) begin
      if (ovf) begin
        q[l] <= neg_s[CW][l] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
        q[l] <= neg_s[CW][l] ? CW'(-qr[CW-1:0]) : qr[CW-1:0];
      end
    end
  end

endmodule
`default_nettype wire

### hdl/triangle_gradient_coefficients.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_gradient_coefficients
// scaled in-plane edge perpendiculars (n x edge)/(n.n) for one triangle
// ----------------------------------------------------------------------------
// throughput: one request per cycle outside reset, set by the fully pipelined datapath;
//   the bit-serial divider spends one register stage per quotient bit
// busy follows rst; no request is taken during reset
// reset clears the valid pipeline only; done stays low until results arrive
// results are shown for one cycle on done; the receiver cannot stall
module triangle_gradient_coefficients import tgc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] a_x,
  input  logic signed [COORD_BITS-1:0] a_y,
  input  logic signed [COORD_BITS-1:0] a_z,
  input  logic signed [COORD_BITS-1:0] b_x,
  input  logic signed [COORD_BITS-1:0] b_y,
  input  logic signed [COORD_BITS-1:0] b_z,
  input  logic signed [COORD_BITS-1:0] c_x,
  input  logic signed [COORD_BITS-1:0] c_y,
  input  logic signed [COORD_BITS-1:0] c_z,
  input  logic [INDEX_BITS-1:0]        a_index,
  input  logic [INDEX_BITS-1:0]        b_index,
  input  logic [INDEX_BITS-1:0]        c_index,
  output logic                         done,
  output logic signed [COORD_BITS-1:0] perp13_x,
  output logic signed [COORD_BITS-1:0] perp13_y,
  output logic signed [COORD_BITS-1:0] perp13_z,
  output logic signed [COORD_BITS-1:0] perp21_x,
  output logic signed [COORD_BITS-1:0] perp21_y,
  output logic signed [COORD_BITS-1:0] perp21_z,
  output logic [INDEX_BITS-1:0]        out_a_index,
  output logic [INDEX_BITS-1:0]        out_b_index,
  output logic [INDEX_BITS-1:0]        out_c_index,
  output logic                         degenerate
);

  localparam int C    = COORD_BITS;
  localparam int EW   = C + 1;          // edge
  localparam int PW   = 2 * EW;         // edge product
  localparam int NW   = PW + 1;         // normal component
  localparam int LW   = NW / 2;         // low split of normal (unsigned)
  localparam int HW   = NW - LW;        // high split of normal (signed)
  localparam int SQW  = 2 * NW;         // squared normal component
  localparam int DW   = SQW + 2;        // n.n
  localparam int PPW  = NW + EW;        // normal times edge
  localparam int XW   = PPW + 1;        // cross product component
  localparam int P    = C + 9;          // last register stage before output
  localparam int LAT  = P + 1;

  // the whole pipeline advances every cycle; only reset holds requests off
  assign busy = rst;

  logic acc;
  assign acc = start && !busy;

  logic signed [C-1:0] va [0:2];
  logic signed [C-1:0] vb [0:2];
  logic signed [C-1:0] vc [0:2];
  assign va[0] = a_x; assign va[1] = a_y; assign va[2] = a_z;
  assign vb[0] = b_x; assign vb[1] = b_y; assign vb[2] = b_z;
  assign vc[0] = c_x; assign vc[1] = c_y; assign vc[2] = c_z;

  // valid and index delay lines, one tap per stage
  logic                  vld [1:P];
  logic [INDEX_BITS-1:0] ia  [1:P];
  logic [INDEX_BITS-1:0] ib  [1:P];
  logic [INDEX_BITS-1:0] ic  [1:P];
  logic                  dg  [7:P];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= P; k++) vld[k] <= 1'b0;
    end else begin
      vld[1] <= acc;
      for (int k = 2; k <= P; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    ia[1] <= a_index;
    ib[1] <= b_index;
    ic[1] <= c_index;
    for (int k = 2; k <= P; k++) begin
      ia[k] <= ia[k-1];
      ib[k] <= ib[k-1];
      ic[k] <= ic[k-1];
    end
  end

  // stage 1: edges
  logic signed [EW-1:0] e32_1 [0:2];
  logic signed [EW-1:0] e13_1 [0:2];
  logic signed [EW-1:0] e21_1 [0:2];
  // stage 2: normal partial products
  logic signed [PW-1:0] np_2  [0:2];
  logic signed [PW-1:0] nn_2  [0:2];
  logic signed [EW-1:0] e13_2 [0:2];
  logic signed [EW-1:0] e21_2 [0:2];
  // stage 3: normal
  logic signed [NW-1:0] n_3   [0:2];
  logic signed [EW-1:0] e13_3 [0:2];
  logic signed [EW-1:0] e21_3 [0:2];
  // stage 4: split products (hi/lo of the normal)
  logic signed [2*HW-1:0]     hh_4 [0:2];
  logic signed [HW+LW:0]      hl_4 [0:2];
  logic        [2*LW-1:0]     ll_4 [0:2];
  logic signed [HW+EW-1:0]    ph_4 [0:5];   // positive term, high part
  logic signed [LW+EW:0]      pl_4 [0:5];
  logic signed [HW+EW-1:0]    mh_4 [0:5];   // negative term, high part
  logic signed [LW+EW:0]      ml_4 [0:5];
  // stage 5: recombined products
  logic [SQW-1:0]             sq_5 [0:2];
  logic signed [PPW-1:0]      pp_5 [0:5];
  logic signed [PPW-1:0]      mm_5 [0:5];
  // stage 6: n.n and cross products
  logic [DW-1:0]              d_6;
  logic signed [XW-1:0]       p_6  [0:5];
  // stage 7: magnitudes and sign
  logic [DW-1:0]              d_7;
  logic [LANES-1:0][XW-1:0]   mag_7;
  logic [LANES-1:0]           neg_7;
  logic [LANES-1:0][C-1:0]    q_p;

  for (genvar r = 0; r < 3; r++) begin : g_comp
    localparam int A = (r + 1) % 3;
    localparam int B = (r + 2) % 3;

    logic        [LW-1:0] nl [0:2];
    logic signed [HW-1:0] nh [0:2];
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        nl[k] = n_3[k][LW-1:0];
        nh[k] = n_3[k][NW-1:LW];
      end
    end

    always_ff @(posedge clk) begin
      // edges v32 = c - b, v13 = a - c, v21 = b - a
      e32_1[r] <= EW'(vc[r]) - EW'(vb[r]);
      e13_1[r] <= EW'(va[r]) - EW'(vc[r]);
      e21_1[r] <= EW'(vb[r]) - EW'(va[r]);

      // n = v32 x v13
      np_2[r]  <= e32_1[A] * e13_1[B];
      nn_2[r]  <= e32_1[B] * e13_1[A];
      e13_2[r] <= e13_1[r];
      e21_2[r] <= e21_1[r];

      n_3[r]   <= NW'(np_2[r]) - NW'(nn_2[r]);
      e13_3[r] <= e13_2[r];
      e21_3[r] <= e21_2[r];

      // n.n per component from hi/lo pieces
      hh_4[r] <= nh[r] * nh[r];
      hl_4[r] <= nh[r] * $signed({1'b0, nl[r]});
      ll_4[r] <= nl[r] * nl[r];

      // n x v13 on lanes 0..2, n x v21 on lanes 3..5
      ph_4[r]   <= nh[A] * e13_3[B];
      pl_4[r]   <= $signed({1'b0, nl[A]}) * e13_3[B];
      mh_4[r]   <= nh[B] * e13_3[A];
      ml_4[r]   <= $signed({1'b0, nl[B]}) * e13_3[A];
      ph_4[r+3] <= nh[A] * e21_3[B];
      pl_4[r+3] <= $signed({1'b0, nl[A]}) * e21_3[B];
      mh_4[r+3] <= nh[B] * e21_3[A];
      ml_4[r+3] <= $signed({1'b0, nl[B]}) * e21_3[A];

      sq_5[r] <= SQW'((SQW'(hh_4[r]) <<< (2 * LW)) + (SQW'(hl_4[r]) <<< (LW + 1))
                      + $signed(SQW'({1'b0, ll_4[r]})));
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    always_ff @(posedge clk) begin
      pp_5[l] <= (PPW'(ph_4[l]) <<< LW) + PPW'(pl_4[l]);
      mm_5[l] <= (PPW'(mh_4[l]) <<< LW) + PPW'(ml_4[l]);
      p_6[l]  <= XW'(pp_5[l]) - XW'(mm_5[l]);
      neg_7[l] <= p_6[l][XW-1];
      mag_7[l] <= p_6[l][XW-1] ? XW'(-p_6[l]) : XW'(p_6[l]);
    end
  end

  // zero-area flag is born at stage 7 and rides along with the divider
  always_ff @(posedge clk) begin
    d_6   <= DW'(sq_5[0]) + DW'(sq_5[1]) + DW'(sq_5[2]);
    d_7   <= d_6;
    dg[7] <= (d_6 == '0);
    for (int k = 8; k <= P; k++) dg[k] <= dg[k-1];
  end

  tgc_div #(
    .CW (C),
    .DW (DW),
    .XW (XW)
  ) u_div (
    .clk (clk),
    .d   (d_7),
    .mag (mag_7),
    .neg (neg_7),
    .q   (q_p)
  );

  // output register; zero area forces zero coefficients
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[P];
    end
  end

  always_ff @(posedge clk) begin
    perp13_x    <= dg[P] ? '0 : q_p[0];
    perp13_y    <= dg[P] ? '0 : q_p[1];
    perp13_z    <= dg[P] ? '0 : q_p[2];
    perp21_x    <= dg[P] ? '0 : q_p[3];
    perp21_y    <= dg[P] ? '0 : q_p[4];
    perp21_z    <= dg[P] ? '0 : q_p[5];
    out_a_index <= ia[P];
    out_b_index <= ib[P];
    out_c_index <= ic[P];
    degenerate  <= dg[P];
  end

  // every result on done must stem from an accepted request
  a_done_lat : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(acc, LAT))
    else $error("result without matching request");

  // a degenerate triangle carries zero coefficients
  a_degen_zero : assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (perp13_x == '0 && perp13_y == '0 && perp13_z == '0 &&
                              perp21_x == '0 && perp21_y == '0 && perp21_z == '0))
    else $error("degenerate result with nonzero coefficients");

  // requests are never taken while in reset
  a_busy_rst : assert property (@(posedge clk)
    rst |=> !vld[1])
    else $error("request taken during reset");

endmodule
`default_nettype wire
